// ===== rtl/core/arqws_pkg.sv =====
// Shared types and constants of the sliding-window ARQ sender.
`timescale 1ns / 1ps

package arqws_pkg;

  localparam int DATA_W    = 64;   // message_data / frame_data
  localparam int LEN_W     = 4;    // message_length / frame_length
  localparam int ACK_W     = 8;    // ack_seq
  localparam int FSEQ_W    = 8;    // frame_seq
  localparam int TMO_W     = 16;   // timeout_ticks
  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 80;

  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd100;

  typedef enum logic [1:0] {
    OP_MSG  = 2'd0,
    OP_ACK  = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // Control part of one result, passed from the control stage to the output pipe.
  typedef struct packed {
    logic              frame_valid;
    logic              frame_is_resend;
    logic              from_store;
    logic              message_rejected;
    logic              window_full;
    logic              transfer_done;
    logic [FSEQ_W-1:0] frame_seq;
  } result_ctl_t;

endpackage

// ===== rtl/core/arqws_store.sv =====
// Window store: one synchronous memory of frame data and length, one write and one read port.
`timescale 1ns / 1ps

module arqws_store #(
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3,
  parameter int WORD_W = 68
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds between reads, so a stalled result keeps its frame.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/arqws_ctrl.sv =====
// Window control: sequence numbers, timer and decisions for each input transaction.
`timescale 1ns / 1ps

module arqws_ctrl
  import arqws_pkg::*;
#(
  parameter int WINDOW_DEPTH = 8,
  parameter int SEQ_BITS     = 8,
  parameter int MSG_BYTES    = 8,
  parameter int SLOT_W       = 3
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [TMO_W-1:0]       cfg_wdata,
  input  logic                   in_accept,
  input  op_t                    opcode,
  input  logic [DATA_W-1:0]      message_data,
  input  logic [LEN_W-1:0]       message_length,
  input  logic [ACK_W-1:0]       ack_seq,
  output logic                   wr_en,
  output logic [SLOT_W-1:0]      wr_addr,
  output logic [MSG_BYTES*8-1:0] wr_payload,
  output logic [LEN_W-1:0]       wr_len,
  output logic                   rd_en,
  output logic [SLOT_W-1:0]      rd_addr,
  output result_ctl_t            ctl
);

  localparam int SEQ_HALF  = 1 << (SEQ_BITS - 1);
  localparam int WIN_LIMIT = (WINDOW_DEPTH < SEQ_HALF) ? WINDOW_DEPTH : SEQ_HALF;
  localparam int SUM_W     = $clog2(2 * WINDOW_DEPTH) + 1;
  localparam int MDW       = MSG_BYTES * 8;

  localparam logic [SEQ_BITS:0]   LIMIT_X = (SEQ_BITS + 1)'(WIN_LIMIT);
  localparam logic [SUM_W-1:0]    DEPTH_X = SUM_W'(WINDOW_DEPTH);
  localparam logic [SLOT_W-1:0]   LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);
  localparam logic [LEN_W-1:0]    MAX_LEN = LEN_W'(MSG_BYTES);

  logic [SEQ_BITS-1:0] base_seq, base_seq_next;
  logic [SEQ_BITS-1:0] next_seq, next_seq_next;
  logic [SLOT_W-1:0]   base_slot, base_slot_next;
  logic [SLOT_W-1:0]   next_slot, next_slot_next;
  logic                source_ended, source_ended_next;
  logic                finished, finished_next;
  logic [TMO_W-1:0]    idle_ticks, idle_ticks_next;
  logic [TMO_W-1:0]    timeout_ticks;

  logic [SEQ_BITS-1:0]       outstanding;
  logic                      full_now;
  logic [LEN_W-1:0]          len_clamp;
  logic [MDW-1:0]            data_masked;
  logic [SEQ_BITS+ACK_W-1:0] ack_wide;
  logic [SEQ_BITS-1:0]       ack;
  logic [SEQ_BITS-1:0]       ack_gap;
  logic                      ack_adv;
  logic                      ack_dup;
  logic [SEQ_BITS+SUM_W-1:0] dist_wide;
  logic [SUM_W-1:0]          slot_sum;
  logic [SUM_W-1:0]          slot_adj;
  logic [SEQ_BITS-1:0]       out_after;
  logic [SEQ_BITS+7:0]       seq_wide;
  logic [SEQ_BITS-1:0]       send_seq;
  logic                      send_new;
  logic                      send_old;
  logic                      msg_reject;

  assign outstanding = next_seq - base_seq;
  assign full_now    = source_ended || ({1'b0, outstanding} >= LIMIT_X);
  assign len_clamp   = (message_length > MAX_LEN) ? MAX_LEN : message_length;

  always_comb begin
    for (int i = 0; i < MSG_BYTES; i++) begin
      data_masked[i*8 +: 8] = (LEN_W'(i) < len_clamp) ? message_data[i*8 +: 8] : 8'h00;
    end
  end

  assign ack_wide = {{SEQ_BITS{1'b0}}, ack_seq};
  assign ack      = ack_wide[SEQ_BITS-1:0];
  assign ack_gap  = ack - base_seq;
  // A valid advance lies in the forward half of the sequence space and not past next_seq.
  assign ack_adv  = (ack_gap != '0) && !ack_gap[SEQ_BITS-1] && (ack_gap <= outstanding);
  assign ack_dup  = (ack_gap == '0) && (outstanding != '0);

  // The slot pointer moves by the same distance, at most one wrap of the window.
  assign dist_wide = {{SUM_W{1'b0}}, ack_gap};
  assign slot_sum  = SUM_W'(base_slot) + dist_wide[SUM_W-1:0];
  assign slot_adj  = (slot_sum >= DEPTH_X) ? (slot_sum - DEPTH_X) : slot_sum;

  always_comb begin
    base_seq_next     = base_seq;
    next_seq_next     = next_seq;
    base_slot_next    = base_slot;
    next_slot_next    = next_slot;
    source_ended_next = source_ended;
    finished_next     = finished;
    idle_ticks_next   = idle_ticks;
    send_new          = 1'b0;
    send_old          = 1'b0;
    msg_reject        = 1'b0;
    if (in_accept) begin
      case (opcode)
        OP_MSG: begin
          if (full_now) begin
            msg_reject = 1'b1;
          end else begin
            send_new        = 1'b1;
            next_seq_next   = next_seq + 1'b1;
            next_slot_next  = (next_slot == LAST_SLOT) ? '0 : next_slot + 1'b1;
            idle_ticks_next = '0;
            if (len_clamp == '0) begin
              source_ended_next = 1'b1;
            end
          end
        end
        OP_ACK: begin
          if (ack_adv) begin
            base_seq_next  = ack;
            base_slot_next = slot_adj[SLOT_W-1:0];
            if (source_ended && (ack == next_seq)) begin
              finished_next = 1'b1;
            end
          end else if (ack_dup) begin
            send_old        = 1'b1;
            idle_ticks_next = '0;
          end
        end
        OP_TICK: begin
          if (outstanding != '0) begin
            if (idle_ticks >= timeout_ticks) begin
              send_old        = 1'b1;
              idle_ticks_next = '0;
            end else begin
              idle_ticks_next = idle_ticks + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_after = next_seq_next - base_seq_next;
  assign send_seq  = send_new ? next_seq : base_seq;
  assign seq_wide  = {8'h00, send_seq};

  always_comb begin
    ctl.frame_valid      = send_new || send_old;
    ctl.frame_is_resend  = send_old;
    ctl.from_store       = send_old;
    ctl.message_rejected = msg_reject;
    ctl.window_full      = source_ended_next || ({1'b0, out_after} >= LIMIT_X);
    ctl.transfer_done    = finished_next;
    ctl.frame_seq        = (send_new || send_old) ? seq_wide[FSEQ_W-1:0] : '0;
  end

  assign wr_en      = send_new;
  assign wr_addr    = next_slot;
  assign wr_payload = data_masked;
  assign wr_len     = len_clamp;
  assign rd_en      = send_old;
  assign rd_addr    = base_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_seq     <= '0;
      next_seq     <= '0;
      base_slot    <= '0;
      next_slot    <= '0;
      source_ended <= 1'b0;
      finished     <= 1'b0;
      idle_ticks   <= '0;
    end else begin
      base_seq     <= base_seq_next;
      next_seq     <= next_seq_next;
      base_slot    <= base_slot_next;
      next_slot    <= next_slot_next;
      source_ended <= source_ended_next;
      finished     <= finished_next;
      idle_ticks   <= idle_ticks_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_ticks <= cfg_wdata;
    end
  end

  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, outstanding} <= LIMIT_X)
    else $error("outstanding frames exceed the window limit");

  a_finish_empty: assert property (@(posedge clk) disable iff (rst)
    finished |-> (source_ended && (base_seq == next_seq)))
    else $error("finished with frames still outstanding");

  a_resend_outstanding: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (outstanding != '0))
    else $error("resend with an empty window");

  a_send_advances: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (next_seq == SEQ_BITS'($past(next_seq) + 1'b1)))
    else $error("new frame did not advance next_seq");

endmodule

// ===== rtl/core/arqws_out.sv =====
// Output pipe: joins store read data with the result control and holds the result register.
`timescale 1ns / 1ps

module arqws_out
  import arqws_pkg::*;
#(
  parameter int MSG_BYTES = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_accept,
  output logic                   in_ready,
  input  result_ctl_t            ctl,
  input  logic [MSG_BYTES*8-1:0] new_payload,
  input  logic [LEN_W-1:0]       new_len,
  input  logic [MSG_BYTES*8-1:0] store_payload,
  input  logic [LEN_W-1:0]       store_len,
  output logic                   res_valid,
  input  logic                   res_ready,
  output result_ctl_t            res_ctl,
  output logic [DATA_W-1:0]      res_data,
  output logic [LEN_W-1:0]       res_len
);

  localparam int MDW = MSG_BYTES * 8;

  logic              s1_valid;
  result_ctl_t       s1_ctl;
  logic [MDW-1:0]    s1_payload;
  logic [LEN_W-1:0]  s1_len;
  logic              s2_adv;
  logic [MDW-1:0]    sel_payload;
  logic [LEN_W-1:0]  sel_len;

  assign s2_adv   = !res_valid || res_ready;
  assign in_ready = !s1_valid || s2_adv;

  // Stage 1 holds the transaction while the store read is registered; the read data stays put while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_ctl     <= ctl;
      s1_payload <= new_payload;
      s1_len     <= new_len;
    end
  end

  always_comb begin
    if (!s1_ctl.frame_valid) begin
      sel_payload = '0;
      sel_len     = '0;
    end else if (s1_ctl.from_store) begin
      sel_payload = store_payload;
      sel_len     = store_len;
    end else begin
      sel_payload = s1_payload;
      sel_len     = s1_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s2_adv) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      res_ctl  <= s1_ctl;
      res_data <= DATA_W'(sel_payload);
      res_len  <= sel_len;
    end
  end

endmodule

// ===== rtl/core/arq_window_sender.sv =====
// Top level of the sliding-window ARQ sender with stream ports.
// An accepted input transaction passes through the stage-1 register, then the result register.
// Throughput: one input transaction per cycle while the output is not stalled; the window store is read and
// written through one port each, and every event touches at most one entry.
// Reset (rst, synchronous) clears sequence numbers, timer and flags and sets
// timeout_ticks to 100; the window store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module arq_window_sender
  import arqws_pkg::*;
#(
  parameter int WINDOW_DEPTH = 8,
  parameter int SEQ_BITS     = 8,
  parameter int MSG_BYTES    = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [TMO_W-1:0]     cfg_wdata,    // timeout_ticks
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,      // message_data, message_length, ack_seq, pad
  input  logic [1:0]           s_tuser,      // opcode
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,      // frame_seq, frame_data, frame_length,
                                             // message_rejected, window_full,
                                             // transfer_done, pad
  output logic [1:0]           m_tuser       // frame_valid, frame_is_resend
);

  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int MDW    = MSG_BYTES * 8;
  localparam int WORD_W = MDW + LEN_W;

  logic              in_accept;
  result_ctl_t       ctl;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [MDW-1:0]    wr_payload;
  logic [LEN_W-1:0]  wr_len;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic [WORD_W-1:0] rd_word;
  result_ctl_t       res_ctl;
  logic [DATA_W-1:0] res_data;
  logic [LEN_W-1:0]  res_len;

  assign in_accept = s_tvalid && s_tready;

  arqws_ctrl #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SEQ_BITS     (SEQ_BITS),
    .MSG_BYTES    (MSG_BYTES),
    .SLOT_W       (SLOT_W)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_accept      (in_accept),
    .opcode         (op_t'(s_tuser)),
    .message_data   (s_tdata[63:0]),
    .message_length (s_tdata[67:64]),
    .ack_seq        (s_tdata[75:68]),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_payload     (wr_payload),
    .wr_len         (wr_len),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .ctl            (ctl)
  );

  arqws_store #(
    .DEPTH  (WINDOW_DEPTH),
    .ADDR_W (SLOT_W),
    .WORD_W (WORD_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({wr_len, wr_payload}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  arqws_out #(
    .MSG_BYTES (MSG_BYTES)
  ) u_out (
    .clk           (clk),
    .rst           (rst),
    .in_accept     (in_accept),
    .in_ready      (s_tready),
    .ctl           (ctl),
    .new_payload   (wr_payload),
    .new_len       (wr_len),
    .store_payload (rd_word[MDW-1:0]),
    .store_len     (rd_word[WORD_W-1:MDW]),
    .res_valid     (m_tvalid),
    .res_ready     (m_tready),
    .res_ctl       (res_ctl),
    .res_data      (res_data),
    .res_len       (res_len)
  );

  assign m_tdata = {1'b0,
                    res_ctl.transfer_done,
                    res_ctl.window_full,
                    res_ctl.message_rejected,
                    res_len,
                    res_data,
                    res_ctl.frame_seq};
  assign m_tuser = {res_ctl.frame_is_resend, res_ctl.frame_valid};

endmodule
